// ----- hw/rtl/dfd_pkg.sv -----
// Shared types and constants for the decimating FM discriminator.
// Holds the CORDIC arctangent table, fixed field widths and the queue status struct.
// No dependencies.
package dfd_pkg;

  localparam int DEC_W        = 11;  // decimation register width
  localparam int PHASE_W      = 16;  // phase_step width
  localparam int ANG_W        = 32;  // angle accumulator, full turn = 2^32
  localparam int CORDIC_STEPS = 30;
  localparam int ITER_W       = 5;   // indexes CORDIC_STEPS entries
  localparam int CW           = 33;  // CORDIC x/y datapath width

  localparam logic [ANG_W-1:0] ANG_PI       = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ANG_HALF_LSB = 32'h0000_8000;

  // request function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // atan(2^-k) scaled so that a full turn is 2^32
  function automatic logic [ANG_W-1:0] atan_lookup(input logic [ITER_W-1:0] k);
    logic [ANG_W-1:0] v;
    case (k)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/dfd_front.sv -----
// Front end: takes requests, runs the boxcar sums and decides when to dump.
// Pushes {current sum, previous sum} into the queue. Depends on dfd_pkg.
module dfd_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 26,
  parameter int CNT_W       = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_func,
  input  logic signed [SAMPLE_BITS-1:0] in_i_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_q_sample,
  output logic                          in_stall,
  input  logic [CNT_W-1:0]              dec_eff,
  input  dfd_pkg::q_stat_t              q_stat,
  output logic                          push,
  output logic [4*SUM_W-1:0]            push_data
);
  import dfd_pkg::*;

  logic signed [SUM_W-1:0] sum_i_r, sum_q_r, last_i_r, last_q_r;
  logic signed [SUM_W-1:0] sum_i_nxt, sum_q_nxt, last_i_nxt, last_q_nxt;
  logic signed [SUM_W-1:0] acc_i, acc_q;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, cnt_inc;
  logic                    accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign acc_i   = sum_i_r + SUM_W'(in_i_sample);
  assign acc_q   = sum_q_r + SUM_W'(in_q_sample);
  assign cnt_inc = cnt_r + 1'b1;

  assign push_data = {acc_i, acc_q, last_i_r, last_q_r};

  always_comb begin
    sum_i_nxt  = sum_i_r;
    sum_q_nxt  = sum_q_r;
    last_i_nxt = last_i_r;
    last_q_nxt = last_q_r;
    cnt_nxt    = cnt_r;
    push       = 1'b0;
    if (accept) begin
      if (in_func == FUNC_CLEAR) begin
        sum_i_nxt  = '0;
        sum_q_nxt  = '0;
        last_i_nxt = '0;
        last_q_nxt = '0;
        cnt_nxt    = '0;
      end else if (cnt_inc >= dec_eff) begin
        // dump: hand off the pair, current becomes previous
        push       = 1'b1;
        last_i_nxt = acc_i;
        last_q_nxt = acc_q;
        sum_i_nxt  = '0;
        sum_q_nxt  = '0;
        cnt_nxt    = '0;
      end else begin
        sum_i_nxt = acc_i;
        sum_q_nxt = acc_q;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_i_r  <= '0;
      sum_q_r  <= '0;
      last_i_r <= '0;
      last_q_r <= '0;
      cnt_r    <= '0;
    end else begin
      sum_i_r  <= sum_i_nxt;
      sum_q_r  <= sum_q_nxt;
      last_i_r <= last_i_nxt;
      last_q_r <= last_q_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/dfd_queue.sv -----
// Two-entry queue between the front end and the discriminator back end.
// Register based; head is read combinationally. Depends on dfd_pkg.
module dfd_queue #(
  parameter int WIDTH = 104
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output dfd_pkg::q_stat_t q_stat
);
  import dfd_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

// ----- hw/rtl/dfd_back.sv -----
// Back end: conjugate product, normalisation and 30-step CORDIC angle.
// One dump at a time through a small sequencer; owns the result register. Depends on dfd_pkg.
module dfd_back #(
  parameter int SUM_W = 26
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dfd_pkg::q_stat_t                  q_stat,
  input  logic [4*SUM_W-1:0]                q_data,
  output logic                              pop,
  output logic                              out_valid,
  output logic signed [dfd_pkg::PHASE_W-1:0] out_phase_step,
  input  logic                              out_stall
);
  import dfd_pkg::*;

  localparam int SH1_MAX = (SUM_W > 30) ? SUM_W - 30 : 0;
  localparam int SH1_W   = $clog2(SH1_MAX + 2);
  localparam int SC_W    = (SUM_W > 31) ? 31 : SUM_W;
  localparam int P_W     = 2 * SC_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_MAG   = 3'd4;
  localparam logic [2:0] S_NORM  = 3'd5;
  localparam logic [2:0] S_ITER  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [ITER_W-1:0]       iter_r, iter_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [PHASE_W-1:0] out_ps_r;

  logic signed [SUM_W-1:0] rci_r, rcq_r, rpi_r, rpq_r;
  logic [SH1_W-1:0]        s1_r;
  logic signed [SC_W-1:0]  sci_r, scq_r, spi_r, spq_r;
  logic signed [2*SC_W-1:0] pii_r, pqq_r, pqi_r, piq_r;
  logic signed [P_W-1:0]   x_r, y_r;
  logic [P_W-1:0]          mor_r;
  logic signed [CW-1:0]    cx_r, cy_r;
  logic [ANG_W-1:0]        z_r;
  logic                    zero_r;

  // head unpack and prescale shift
  logic signed [SUM_W-1:0] h_ci, h_cq, h_pi, h_pq;
  logic [SUM_W-1:0]        h_mor;
  logic [SH1_W-1:0]        s1;

  logic [P_W-1:0]          mag_x, mag_y;
  logic                    big8, big1;
  logic signed [CW-1:0]    xs, ys, xsh, ysh;
  logic [ANG_W-1:0]        atan_k, z_round;
  logic                    done_fire;

  function automatic logic [SUM_W-1:0] mag_s(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  assign h_ci  = q_data[4*SUM_W-1 -: SUM_W];
  assign h_cq  = q_data[3*SUM_W-1 -: SUM_W];
  assign h_pi  = q_data[2*SUM_W-1 -: SUM_W];
  assign h_pq  = q_data[SUM_W-1 -: SUM_W];
  assign h_mor = mag_s(h_ci) | mag_s(h_cq) | mag_s(h_pi) | mag_s(h_pq);

  // smallest shift bringing every magnitude below 2^30
  always_comb begin
    s1 = SH1_W'(SH1_MAX);
    for (int s = SH1_MAX; s >= 0; s--) begin
      if (((h_mor >> s) >> 30) == '0) begin
        s1 = SH1_W'(s);
      end
    end
  end

  assign mag_x = x_r[P_W-1] ? P_W'(-x_r) : P_W'(x_r);
  assign mag_y = y_r[P_W-1] ? P_W'(-y_r) : P_W'(y_r);
  assign big8  = ((mor_r >> 37) != '0);
  assign big1  = ((mor_r >> 29) != '0);

  assign xs      = CW'(x_r);
  assign ys      = CW'(y_r);
  assign xsh     = cx_r >>> iter_r;
  assign ysh     = cy_r >>> iter_r;
  assign atan_k  = atan_lookup(iter_r);
  assign z_round = z_r + ANG_HALF_LSB;

  assign done_fire = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_MAG;
      S_MAG:   state_nxt = S_NORM;
      S_NORM: begin
        if (mor_r == '0) begin
          state_nxt = S_DONE;
        end else if (!big8 && !big1) begin
          iter_nxt  = '0;
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          rci_r <= h_ci;
          rcq_r <= h_cq;
          rpi_r <= h_pi;
          rpq_r <= h_pq;
          s1_r  <= s1;
        end
      end
      S_SCALE: begin
        sci_r <= SC_W'(rci_r >>> s1_r);
        scq_r <= SC_W'(rcq_r >>> s1_r);
        spi_r <= SC_W'(rpi_r >>> s1_r);
        spq_r <= SC_W'(rpq_r >>> s1_r);
      end
      S_MUL: begin
        pii_r <= sci_r * spi_r;
        pqq_r <= scq_r * spq_r;
        pqi_r <= scq_r * spi_r;
        piq_r <= sci_r * spq_r;
      end
      S_ADD: begin
        // cur * conj(prev)
        x_r <= P_W'(pii_r) + P_W'(pqq_r);
        y_r <= P_W'(pqi_r) - P_W'(piq_r);
      end
      S_MAG: mor_r <= mag_x | mag_y;
      S_NORM: begin
        // shift counted on the original magnitude, so floor steps compose exactly
        if (mor_r == '0) begin
          zero_r <= 1'b1;
        end else if (big8) begin
          x_r   <= x_r >>> 8;
          y_r   <= y_r >>> 8;
          mor_r <= mor_r >> 8;
        end else if (big1) begin
          x_r   <= x_r >>> 1;
          y_r   <= y_r >>> 1;
          mor_r <= mor_r >> 1;
        end else begin
          zero_r <= 1'b0;
          if (xs < 0) begin
            cx_r <= -xs;
            cy_r <= -ys;
            z_r  <= ANG_PI;
          end else begin
            cx_r <= xs;
            cy_r <= ys;
            z_r  <= '0;
          end
        end
      end
      S_ITER: begin
        if (!cy_r[CW-1]) begin
          cx_r <= cx_r + ysh;
          cy_r <= cy_r - xsh;
          z_r  <= z_r + atan_k;
        end else begin
          cx_r <= cx_r - ysh;
          cy_r <= cy_r + xsh;
          z_r  <= z_r - atan_k;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          out_ps_r <= zero_r ? '0 : z_round[ANG_W-1 -: PHASE_W];
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_phase_step = out_ps_r;

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER) |-> (iter_r < ITER_W'(CORDIC_STEPS)))
    else $error("CORDIC step index out of range");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && state_r == S_IDLE))
    else $error("back end not idle after reset");

endmodule

// ----- hw/rtl/decimating_fm_discriminator_top.sv -----
// Top level of the decimating FM discriminator (integrate-and-dump quadrature type).
// Instantiates dfd_front, dfd_queue and dfd_back; holds the decimation register.
// Depends on dfd_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): one request per accepted edge. in_func picks a
//    sample (in_i_sample, in_q_sample summed into the boxcar) or a clear, which zeroes the
//    sums, the sample count and the previous vector and gives no result.
//  - After "decimation" samples the sums are dumped and one phase_step appears on the
//    output channel (out_valid / out_stall), 32768 = pi. Zero vectors give 0.
//  - Config: cfg_wr_en / cfg_wr_data write the decimation; 0 acts as 1, values above
//    MAX_DECIMATION saturate. Write only while the block is idle.
//  - Throughput: one request per cycle while the two-entry queue has room. The back end
//    handles one dump at a time (pop, prescale, products, sum, magnitude, normalise, 30
//    CORDIC steps, result), plus up to 9 normalising shifts for large products, and
//    starts the next dump only after the result is taken into the output register.
//  - Reset (rst_n low, synchronous) zeroes the sums, empties the queue, drops out_valid
//    and sets decimation to 1. A stalled result holds in the output register; the back
//    end waits, the queue fills and in_stall rises.
module decimating_fm_discriminator_top #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_DECIMATION = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic signed [SAMPLE_BITS-1:0]      in_i_sample,
  input  logic signed [SAMPLE_BITS-1:0]      in_q_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dfd_pkg::PHASE_W-1:0] out_phase_step,
  input  logic                               cfg_wr_en,
  input  logic [dfd_pkg::DEC_W-1:0]          cfg_wr_data
);
  import dfd_pkg::*;

  // sum width covers MAX_DECIMATION full-scale samples
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_DECIMATION);
  localparam int CNT_W = $clog2(MAX_DECIMATION + 1);
  localparam int Q_W   = 4 * SUM_W;

  // decimation held already clamped to 1..MAX_DECIMATION
  logic [CNT_W-1:0] dec_eff_r, dec_eff_nxt;

  q_stat_t          q_stat;
  logic             push, pop;
  logic [Q_W-1:0]   push_data, pop_data;

  always_comb begin
    dec_eff_nxt = dec_eff_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        dec_eff_nxt = CNT_W'(1);
      end else if (cfg_wr_data > MAX_DECIMATION) begin
        dec_eff_nxt = CNT_W'(MAX_DECIMATION);
      end else begin
        dec_eff_nxt = CNT_W'(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_eff_r <= CNT_W'(1);
    end else begin
      dec_eff_r <= dec_eff_nxt;
    end
  end

  dfd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_func     (in_func),
    .in_i_sample (in_i_sample),
    .in_q_sample (in_q_sample),
    .in_stall    (in_stall),
    .dec_eff     (dec_eff_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  dfd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  dfd_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_phase_step (out_phase_step),
    .out_stall      (out_stall)
  );

endmodule
